[sv/utf16_to_utf8_encoder_top_assert.svh]
// Assertion macros for the UTF-16 to UTF-8 encoder.
// Each macro expects clk and rst in scope.
`ifndef UTF16_TO_UTF8_ENCODER_TOP_ASSERT_SVH
`define UTF16_TO_UTF8_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define U16U8_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u16u8 assertion failed");

// Next-cycle implication.
`define U16U8_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u16u8 assertion failed");

`endif

[sv/u16u8_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package u16u8_pkg;

  // Width of the running byte count.
  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_ONLY = 1'd1;

  localparam logic [15:0] UNIT_HI_FIRST = 16'hD800;
  localparam logic [15:0] UNIT_HI_LAST  = 16'hDBFF;
  localparam logic [15:0] UNIT_LO_FIRST = 16'hDC00;
  localparam logic [15:0] UNIT_LO_LAST  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE     = 21'h10000;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] bytes;  // bytes[0] goes out first
  } utf8_seq_t;

  function automatic utf8_seq_t utf8_encode(input logic [20:0] cp);
    utf8_seq_t s;
    s.bytes = '0;
    if (cp < 21'h80) begin
      s.len = 3'd1;
      s.bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      s.len = 3'd2;
      s.bytes[0] = {3'b110, cp[10:6]};
      s.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < SUPP_BASE) begin
      s.len = 3'd3;
      s.bytes[0] = {4'b1110, cp[15:12]};
      s.bytes[1] = {2'b10, cp[11:6]};
      s.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      s.len = 3'd4;
      s.bytes[0] = {5'b11110, cp[20:18]};
      s.bytes[1] = {2'b10, cp[17:12]};
      s.bytes[2] = {2'b10, cp[11:6]};
      s.bytes[3] = {2'b10, cp[5:0]};
    end
    return s;
  endfunction

endpackage

`default_nettype wire

[sv/utf16_to_utf8_encoder_top.sv]
// Channel   Dir  tdata                          tuser / tlast
// s_*       in   [15:0] code_unit             tuser: first_unit, tlast: last_unit
// m_*       out  [7:0] out_byte, [23:8] count tuser: byte_write, status, string_done
// cfg_*     in   write only: 0 out_limit, 1 count_only
//
// One result per cycle while m_tready is high. A request is decoded in the cycle it is accepted and
// gives 1 to 5 results (UTF-8 bytes, then a terminator or a status result),
// which hold the output register until the last of them has left; the next request
// is taken in the cycle the last result of the current one leaves.
// A stall on m_tready holds the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "utf16_to_utf8_encoder_top_assert.svh"

module utf16_to_utf8_encoder_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output      logic                              s_tready,
  input  wire logic [15:0]                       s_tdata,   // [15:0] code_unit
  input  wire logic [0:0]                        s_tuser,   // [0] first_unit
  input  wire logic                              s_tlast,   // last_unit
  output      logic                              m_tvalid,
  input  wire logic                              m_tready,
  output      logic [23:0]                       m_tdata,   // [7:0] out_byte, [23:8] byte_count
  output      logic [3:0]                        m_tuser,   // [0] byte_write, [2:1] status,
                                                            // [3] string_done
  output      logic                              m_tlast,   // run_last
  input  wire logic                              cfg_wr_en,
  input  wire logic [u16u8_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [u16u8_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import u16u8_pkg::*;

  // configuration
  logic [15:0]      out_limit;
  logic             count_only;

  // string state
  logic [9:0]       held_high;
  logic             high_pending;
  logic [CNT_W-1:0] bytes_so_far;
  status_t          error_code;

  // output register
  logic             o_valid;
  logic [2:0]       nb_left;
  logic             term;
  logic             stat;
  logic             str_last;
  status_t          err_out;
  logic [3:0][7:0]  obuf;
  logic [CNT_W-1:0] cnt_cur;
  logic [CNT_W-1:0] cnt_final;

  // decode of the incoming request
  logic [9:0]       held_high_next;
  logic             high_pending_next;
  logic [CNT_W-1:0] bytes_so_far_next;
  status_t          error_code_next;
  logic [2:0]       nb_next;
  logic             term_next;
  logic             stat_next;
  logic [CNT_W-1:0] cnt_first;
  utf8_seq_t        seq;

  logic run_last;
  logic accept;
  logic take;

  always_comb begin
    logic [20:0]      cp;
    logic             have;
    logic [CNT_W:0]   want;
    logic [CNT_W:0]   limit_ext;
    logic [CNT_W-1:0] base;

    held_high_next    = held_high;
    high_pending_next = high_pending;
    bytes_so_far_next = bytes_so_far;
    error_code_next   = error_code;
    cp                = '0;
    have              = 1'b0;
    nb_next           = 3'd0;
    term_next         = 1'b0;
    base              = '0;
    limit_ext         = (CNT_W+1)'(out_limit);

    if (s_tuser[0]) begin
      held_high_next    = '0;
      high_pending_next = 1'b0;
      bytes_so_far_next = '0;
      error_code_next   = ST_OK;
    end

    if (error_code_next == ST_OK) begin
      if (high_pending_next) begin
        high_pending_next = 1'b0;
        if (s_tdata >= UNIT_LO_FIRST && s_tdata <= UNIT_LO_LAST) begin
          cp   = {1'b0, held_high_next, s_tdata[9:0]} + SUPP_BASE;
          have = 1'b1;
        end else begin
          error_code_next = ST_INVALID;
        end
      end else if (s_tdata >= UNIT_HI_FIRST && s_tdata <= UNIT_HI_LAST) begin
        held_high_next    = s_tdata[9:0];
        high_pending_next = 1'b1;
      end else begin
        cp   = 21'(s_tdata);
        have = 1'b1;
      end
    end

    seq  = utf8_encode(cp);
    want = {1'b0, bytes_so_far_next} + (CNT_W+1)'(seq.len);

    if (have) begin
      if (count_only) begin
        if (want > {1'b0, CNT_MAX}) begin
          bytes_so_far_next = CNT_MAX;
          error_code_next   = ST_OVERFLOW;
        end else begin
          bytes_so_far_next = want[CNT_W-1:0];
        end
      end else if (want > limit_ext || want > {1'b0, CNT_MAX}) begin
        error_code_next = ST_OVERFLOW;
      end else begin
        nb_next           = seq.len;
        base              = bytes_so_far_next;
        bytes_so_far_next = want[CNT_W-1:0];
      end
    end

    if (s_tlast) begin
      if (error_code_next == ST_OK && high_pending_next) begin
        error_code_next = ST_INVALID;
      end
      high_pending_next = 1'b0;
      if (error_code_next == ST_OK && !count_only) begin
        if ({1'b0, bytes_so_far_next} >= limit_ext) begin
          error_code_next = ST_OVERFLOW;
        end else begin
          term_next = 1'b1;
        end
      end
    end

    // a status result follows when nothing went out or the error code is not OK
    stat_next = (nb_next == 3'd0 && !term_next) || (error_code_next != ST_OK);
    cnt_first = (nb_next != 3'd0) ? base + CNT_W'(1) : bytes_so_far_next;
  end

  // term and stat never both set, so only a lone final byte ends the run early
  assign run_last = (nb_left == 3'd0) || (nb_left == 3'd1 && !term && !stat);
  assign take     = o_valid && m_tready;
  assign s_tready = !o_valid || (m_tready && run_last);
  assign accept   = s_tvalid && s_tready;

  assign m_tvalid   = o_valid;
  assign m_tlast    = run_last;
  assign m_tdata    = {16'(cnt_cur), (nb_left != 3'd0) ? obuf[0] : 8'h00};
  assign m_tuser[0] = (nb_left != 3'd0) || term;
  assign m_tuser[2:1] = (nb_left == 3'd0 && stat) ? err_out : ST_OK;
  assign m_tuser[3] = run_last && str_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_limit    <= 16'hFFFF;
      count_only   <= 1'b0;
      held_high    <= '0;
      high_pending <= 1'b0;
      bytes_so_far <= '0;
      error_code   <= ST_OK;
      o_valid      <= 1'b0;
      nb_left      <= 3'd0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_OUT_LIMIT:  out_limit  <= cfg_data[15:0];
          REG_COUNT_ONLY: count_only <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        held_high    <= held_high_next;
        high_pending <= high_pending_next;
        bytes_so_far <= bytes_so_far_next;
        error_code   <= error_code_next;
        o_valid      <= 1'b1;
        nb_left      <= nb_next;
      end else if (take) begin
        if (run_last) begin
          o_valid <= 1'b0;
        end else begin
          nb_left <= nb_left - 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      obuf      <= seq.bytes;
      term      <= term_next;
      stat      <= stat_next;
      str_last  <= s_tlast;
      err_out   <= error_code_next;
      cnt_cur   <= cnt_first;
      cnt_final <= bytes_so_far_next;
    end else if (take && !run_last) begin
      obuf    <= {8'h00, obuf[3:1]};
      cnt_cur <= (nb_left > 3'd1) ? cnt_cur + CNT_W'(1) : cnt_final;
    end
  end

  `U16U8_ASSERT_IMP(a_status_ends_run, o_valid && !m_tuser[0], run_last)
  `U16U8_ASSERT_IMP(a_write_is_ok, o_valid && m_tuser[0], m_tuser[2:1] == ST_OK)
  `U16U8_ASSERT_IMP(a_no_take_mid_run, o_valid && !run_last, !s_tready)
  `U16U8_ASSERT_IMP(a_term_stat_excl, o_valid, !(term && stat))
  `U16U8_ASSERT_NXT(a_mid_run_holds, o_valid && !run_last, o_valid)

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import u16u8_pkg::*;

  localparam int CYCLE_LIMIT = 100000;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_write;
    logic        run_last;
    status_t     status;
    logic [15:0] byte_count;
    logic        string_done;
  } utf8_result_t;

  // Directed rows: either a register write or a request; typed rows carry the
  // final result of that request written out by hand.
  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [15:0]          data;
    bit                   first;
    bit                   last;
    bit                   typed;
    logic [7:0]           t_byte;
    bit                   t_wr;
    status_t              t_st;
    logic [15:0]          t_cnt;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [15:0]           s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [23:0]           m_tdata;
  logic [3:0]            m_tuser;
  logic                  m_tlast;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int tx_idle_pct = 14;
  int rx_idle_pct = 78;
  int mismatch_count = 0;
  int cycle_count = 0;

  // predictor state
  int           lim_bytes = 65535;
  bit           count_mode = 1'b0;
  logic [9:0]   held_bits = '0;
  bit           pair_open = 1'b0;
  int           byte_total = 0;
  status_t      err_state = ST_OK;
  utf8_result_t expected_utf8[$];

  dir_row_t dir_rows [0:30] = '{
    '{1'b0, REG_OUT_LIMIT, 16'h0041, 1'b1, 1'b0, 1'b1, 8'h41, 1'b1, ST_OK, 16'd1},
    '{1'b0, REG_OUT_LIMIT, 16'h0000, 1'b0, 1'b0, 1'b1, 8'h00, 1'b1, ST_OK, 16'd2},
    '{1'b0, REG_OUT_LIMIT, 16'h007F, 1'b0, 1'b0, 1'b1, 8'h7F, 1'b1, ST_OK, 16'd3},
    '{1'b0, REG_OUT_LIMIT, 16'h0080, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK, 16'd0},
    '{1'b0, REG_OUT_LIMIT, 16'h07FF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK, 16'd0},
    '{1'b0, REG_OUT_LIMIT, 16'h0800, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK, 16'd0},
    '{1'b0, REG_OUT_LIMIT, 16'hFFFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK, 16'd0},
    '{1'b0, REG_OUT_LIMIT, 16'hD800, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, ST_OK, 16'd13},
    '{1'b0, REG_OUT_LIMIT, 16'hDC00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK, 16'd0},
    '{1'b0, REG_OUT_LIMIT, 16'hDBFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK, 16'd0},
    '{1'b0, REG_OUT_LIMIT, 16'hDFFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK, 16'd0},
    // lone low surrogate goes out as three bytes
    '{1'b0, REG_OUT_LIMIT, 16'hDC05, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK, 16'd0},
    '{1'b0, REG_OUT_LIMIT, 16'hD834, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK, 16'd0},
    '{1'b0, REG_OUT_LIMIT, 16'h0041, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, ST_INVALID, 16'd24},
    '{1'b0, REG_OUT_LIMIT, 16'h0042, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0, ST_INVALID, 16'd24},
    '{1'b0, REG_OUT_LIMIT, 16'h0041, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK, 16'd0},
    // high surrogate as the last unit
    '{1'b0, REG_OUT_LIMIT, 16'hD800, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, ST_INVALID, 16'd0},
    '{1'b0, REG_OUT_LIMIT, 16'hDFFF, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK, 16'd0},
    '{1'b1, REG_OUT_LIMIT, 16'd3, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK, 16'd0},
    '{1'b0, REG_OUT_LIMIT, 16'h0041, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK, 16'd0},
    '{1'b0, REG_OUT_LIMIT, 16'h00E9, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK, 16'd0},
    '{1'b0, REG_OUT_LIMIT, 16'h0041, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0, ST_OVERFLOW, 16'd3},
    // terminator does not fit: byte goes out, then overflow status
    '{1'b1, REG_OUT_LIMIT, 16'd1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK, 16'd0},
    '{1'b0, REG_OUT_LIMIT, 16'h0041, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, ST_OVERFLOW, 16'd1},
    '{1'b1, REG_OUT_LIMIT, 16'd0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK, 16'd0},
    '{1'b0, REG_OUT_LIMIT, 16'hD83D, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK, 16'd0},
    '{1'b0, REG_OUT_LIMIT, 16'hDE00, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0, ST_OVERFLOW, 16'd0},
    '{1'b1, REG_COUNT_ONLY, 16'd1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK, 16'd0},
    '{1'b0, REG_OUT_LIMIT, 16'hD83D, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK, 16'd0},
    '{1'b0, REG_OUT_LIMIT, 16'hDE00, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, ST_OK, 16'd4},
    '{1'b0, REG_OUT_LIMIT, 16'h0041, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0, ST_OK, 16'd5}
  };

  utf16_to_utf8_encoder_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic push_result(input logic [7:0] b, input logic wr);
    utf8_result_t r;
    r.out_byte = b;
    r.byte_write = wr;
    r.run_last = 1'b0;
    r.status = err_state;
    r.byte_count = byte_total[15:0];
    r.string_done = 1'b0;
    expected_utf8.push_back(r);
  endtask

  // Expected results of one accepted request; updates the predictor state.
  task automatic encode_unit(input logic [15:0] unit, input bit first, input bit last);
    logic [20:0]  cp;
    logic [20:0]  sh;
    logic [7:0]   lead;
    bit           have;
    int           len;
    int           want;
    int           nres;
    status_t      st_last;
    utf8_result_t r;
    cp = '0;
    have = 1'b0;
    nres = 0;
    st_last = ST_OK;
    if (first) begin
      byte_total = 0;
      err_state = ST_OK;
      pair_open = 1'b0;
      held_bits = '0;
    end
    if (err_state == ST_OK) begin
      if (pair_open) begin
        pair_open = 1'b0;
        if (unit >= UNIT_LO_FIRST && unit <= UNIT_LO_LAST) begin
          cp = {1'b0, held_bits, unit[9:0]} + SUPP_BASE;
          have = 1'b1;
        end else begin
          err_state = ST_INVALID;
        end
      end else if (unit >= UNIT_HI_FIRST && unit <= UNIT_HI_LAST) begin
        held_bits = unit[9:0];
        pair_open = 1'b1;
      end else begin
        cp = {5'd0, unit};
        have = 1'b1;
      end
      if (have) begin
        if (cp < 21'h80) begin
          len = 1;
          lead = 8'h00;
        end else if (cp < 21'h800) begin
          len = 2;
          lead = 8'hC0;
        end else if (cp < 21'h10000) begin
          len = 3;
          lead = 8'hE0;
        end else begin
          len = 4;
          lead = 8'hF0;
        end
        want = byte_total + len;
        if (count_mode) begin
          if (want > int'(CNT_MAX)) begin
            byte_total = int'(CNT_MAX);
            err_state = ST_OVERFLOW;
          end else begin
            byte_total = want;
          end
        end else if (want > lim_bytes || want > int'(CNT_MAX)) begin
          err_state = ST_OVERFLOW;
        end else begin
          for (int i = 0; i < len; i++) begin
            sh = cp >> (6 * (len - 1 - i));
            byte_total++;
            if (i == 0)
              push_result(lead | sh[7:0], 1'b1);
            else
              push_result(8'h80 | {2'b00, sh[5:0]}, 1'b1);
            st_last = err_state;
            nres++;
          end
        end
      end
    end
    if (last) begin
      if (err_state == ST_OK && pair_open)
        err_state = ST_INVALID;
      pair_open = 1'b0;
      if (err_state == ST_OK && !count_mode) begin
        if (byte_total >= lim_bytes) begin
          err_state = ST_OVERFLOW;
        end else begin
          push_result(8'h00, 1'b1);
          st_last = err_state;
          nres++;
        end
      end
    end
    if (nres == 0 || st_last != err_state)
      push_result(8'h00, 1'b0);
    r = expected_utf8.pop_back();
    r.run_last = 1'b1;
    r.string_done = last;
    expected_utf8.push_back(r);
  endtask

  task automatic report_field(input string fname, input logic [15:0] e, input logic [15:0] a);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, e, a);
    mismatch_count++;
  endtask

  task automatic check_result();
    utf8_result_t want;
    if (expected_utf8.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual tdata %h tuser %h tlast %b",
               $time, m_tdata, m_tuser, m_tlast);
      mismatch_count++;
      return;
    end
    want = expected_utf8.pop_front();
    if (m_tdata[7:0] !== want.out_byte)
      report_field("out_byte", 16'(want.out_byte), 16'(m_tdata[7:0]));
    if (m_tuser[0] !== want.byte_write)
      report_field("byte_write", 16'(want.byte_write), 16'(m_tuser[0]));
    if (m_tlast !== want.run_last)
      report_field("run_last", 16'(want.run_last), 16'(m_tlast));
    if (m_tuser[2:1] !== want.status)
      report_field("status", 16'(want.status), 16'(m_tuser[2:1]));
    if (m_tdata[23:8] !== want.byte_count)
      report_field("byte_count", want.byte_count, m_tdata[23:8]);
    if (m_tuser[3] !== want.string_done)
      report_field("string_done", 16'(want.string_done), 16'(m_tuser[3]));
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      check_result();
  end

  // valid stays high after acceptance until the next falling edge decides
  task automatic send_unit(input logic [15:0] unit, input bit first, input bit last);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= unit;
    s_tuser <= first;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    encode_unit(unit, first, last);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_utf8.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_OUT_LIMIT:  lim_bytes = int'(val);
      REG_COUNT_ONLY: count_mode = val[0];
      default: ;
    endcase
  endtask

  // Mostly well-formed strings; some noise units, missing starts or ends.
  task automatic send_string(output int n_units);
    logic [15:0] units[$];
    int          len;
    int          pick;
    bit          no_first;
    bit          no_last;
    len = $urandom_range(1, 10);
    while (units.size() < len) begin
      pick = $urandom_range(99);
      if (pick < 40)
        units.push_back(16'($urandom_range(0, 127)));
      else if (pick < 55)
        units.push_back(16'($urandom_range(16'h0080, 16'h07FF)));
      else if (pick < 70)
        units.push_back(16'($urandom_range(1) ? $urandom_range(16'h0800, 16'hD7FF)
                                              : $urandom_range(16'hE000, 16'hFFFF)));
      else if (pick < 90) begin
        units.push_back(16'($urandom_range(UNIT_HI_FIRST, UNIT_HI_LAST)));
        units.push_back(16'($urandom_range(UNIT_LO_FIRST, UNIT_LO_LAST)));
      end else
        units.push_back(16'($urandom()));
    end
    no_first = ($urandom_range(19) == 0);
    no_last = ($urandom_range(19) == 0);
    foreach (units[i])
      send_unit(units[i], (i == 0) && !no_first, (i == units.size() - 1) && !no_last);
    n_units = units.size();
  endtask

  initial begin
    dir_row_t    row;
    utf8_result_t r;
    int          sent;
    int          n;
    logic [15:0] lim;
    bit          co;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    for (int i = 0; i < $size(dir_rows); i++) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        wait_idle();
        write_reg(row.reg_idx, row.data);
      end else begin
        send_unit(row.data, row.first, row.last);
        if (row.typed) begin
          r = expected_utf8.pop_back();
          r.out_byte = row.t_byte;
          r.byte_write = row.t_wr;
          r.status = row.t_st;
          r.byte_count = row.t_cnt;
          expected_utf8.push_back(r);
        end
      end
    end

    for (int seg = 0; seg < 6; seg++) begin
      wait_idle();
      case (seg)
        0: begin lim = 16'($urandom_range(2, 30)); co = 1'b0; end
        1: begin lim = 16'd0; co = 1'b0; end
        2: begin lim = 16'hFFFF; co = 1'b0; end
        3: begin lim = 16'($urandom_range(1, 60)); co = 1'b1; end
        4: begin lim = 16'($urandom_range(5, 50)); co = 1'b0; end
        default: begin lim = 16'hFFFF; co = 1'b1; end
      endcase
      tx_idle_pct = (seg < 2) ? 14 : (seg < 4) ? 78 : 0;
      rx_idle_pct = (seg < 2) ? 78 : (seg < 4) ? 14 : 0;
      write_reg(REG_OUT_LIMIT, lim);
      write_reg(REG_COUNT_ONLY, {15'd0, co});
      sent = 0;
      while (sent < 28) begin
        send_string(n);
        sent += n;
      end
    end

    wait_idle();
    if (mismatch_count == 0 && expected_utf8.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

[utf16_to_utf8_encoder_top.f]
+incdir+sv
sv/u16u8_pkg.sv
sv/utf16_to_utf8_encoder_top.sv
test/tb_top.sv
